/* sv/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("same-cycle implication failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle implication failed");

`endif

/* sv/spk_pkg.sv */
`timescale 1ns / 1ps

package spk_pkg;

	// field widths
	localparam int W_DIM  = 15;
	localparam int W_MIN  = 11;
	localparam int W_ORG  = 14;
	localparam int W_STAT = 2;
	localparam int W_CFGI = 3;
	localparam int W_CFGD = 15;
	// dividend of the height rounding: height plus granule minus one
	localparam int W_DIV  = W_DIM + 1;

	// register indexes
	localparam logic [W_CFGI-1:0] CFG_ATLAS_W  = 3'd0;
	localparam logic [W_CFGI-1:0] CFG_ATLAS_H  = 3'd1;
	localparam logic [W_CFGI-1:0] CFG_MIN_SIZE = 3'd2;
	localparam logic [W_CFGI-1:0] CFG_ORIGIN_X = 3'd3;
	localparam logic [W_CFGI-1:0] CFG_ORIGIN_Y = 3'd4;

	// result status codes
	localparam logic [W_STAT-1:0] ST_PLACED    = 2'd0;
	localparam logic [W_STAT-1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [W_STAT-1:0] ST_NO_ROOM   = 2'd2;
	localparam logic [W_STAT-1:0] ST_TABLE_FULL = 2'd3;

	// one stripe table entry
	typedef struct packed {
		logic [W_DIM-1:0] height;
		logic [W_DIM-1:0] top;
		logic [W_DIM-1:0] room;
	} stripe_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic place;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic oversize;
		logic div_done;
		logic scan_end;
	} dp_stat_t;

endpackage

/* sv/shelf_rectangle_packer.sv */
`timescale 1ns / 1ps

// Shelf allocator for rectangles in a fixed atlas. A request is taken when
// start is high and busy is low; its single result appears on status, pos_x
// and pos_y for exactly one cycle while done is high, and must be taken then,
// as the block cannot hold it. A request first passes through the remainder
// divider that rounds its height, then scans the stripe table one entry a
// cycle through its registered read port, ending early on the first fit, and
// is then placed; an oversized request skips the wait for the divider and the
// scan. busy drops as done rises, so a new start can be given in the cycle the
// result is shown. The user must see that configuration is written through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce this.
// Geometry writes empty the stripe table at once.
module shelf_rectangle_packer
	import spk_pkg::*;
#(
	parameter int MAX_STRIPES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [W_DIM-1:0]  req_width,
	input  logic [W_DIM-1:0]  req_height,
	output logic              done,
	output logic [W_STAT-1:0] status,
	output logic [W_DIM-1:0]  pos_x,
	output logic [W_DIM-1:0]  pos_y,
	input  logic              cfg_we,
	input  logic [W_CFGI-1:0] cfg_index,
	input  logic [W_CFGD-1:0] cfg_wdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// request sequencing
	spk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// stripe table, rounding and placement
	spk_datapath #(
		.MAX_STRIPES (MAX_STRIPES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.req_width  (req_width),
		.req_height (req_height),
		.cmd        (cmd),
		.stat       (stat),
		.status     (status),
		.pos_x      (pos_x),
		.pos_y      (pos_y)
	);

endmodule

/* sv/spk_rem_div.sv */
`timescale 1ns / 1ps

module spk_rem_div
	import spk_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W_DIV-1:0] dividend,
	input  logic [W_MIN-1:0] divisor,
	output logic [W_MIN-1:0] rem,
	output logic             done
);

	localparam int CNT_W = $clog2(W_DIV + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [W_DIV-1:0] shift_q;
	logic [W_MIN-1:0] rem_q;
	logic [W_MIN:0]   trial;

	// bring down the next dividend bit
	assign trial = {rem_q, shift_q[W_DIV-1]};

	// restoring division, one quotient bit a cycle, remainder kept only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(W_DIV);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (cnt_q != '0) begin
			shift_q <= {shift_q[W_DIV-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= W_MIN'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[W_MIN-1:0];
			end
		end
	end

	assign rem  = rem_q;
	assign done = (cnt_q == '0);

endmodule

/* sv/spk_ctrl.sv */
`timescale 1ns / 1ps

module spk_ctrl
	import spk_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     done
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DIV   = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_PLACE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;

	// sequencing of one request
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.oversize) begin
					state_d = S_PLACE;
				end else if (stat.div_done) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_end) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_PLACE);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

/* sv/spk_datapath.sv */
`timescale 1ns / 1ps

module spk_datapath
	import spk_pkg::*;
#(
	parameter int MAX_STRIPES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [W_CFGI-1:0] cfg_index,
	input  logic [W_CFGD-1:0] cfg_wdata,
	input  logic [W_DIM-1:0]  req_width,
	input  logic [W_DIM-1:0]  req_height,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	output logic [W_STAT-1:0] status,
	output logic [W_DIM-1:0]  pos_x,
	output logic [W_DIM-1:0]  pos_y
);

	localparam int CW = $clog2(MAX_STRIPES + 1);
	localparam int AW = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;

	// configuration and stripe bookkeeping
	logic [W_DIM-1:0]  aw_q;
	logic [W_DIM-1:0]  ah_q;
	logic [W_MIN-1:0]  g_q;
	logic [W_ORG-1:0]  ox_q;
	logic [W_ORG-1:0]  oy_q;
	logic [CW-1:0]     count_q;
	logic [W_DIM-1:0]  vroom_q;

	// request
	logic [W_DIM-1:0]  w_q;
	logic [W_DIM-1:0]  h_q;
	logic [W_DIV-1:0]  v_q;
	logic [W_DIV-1:0]  v_in;
	logic              oversize_q;
	logic [W_DIV-1:0]  rh_q;
	logic [W_DIV-1:0]  rh_d;

	// divider
	logic [W_MIN-1:0]  rem;
	logic              div_done;

	// stripe table and scan
	stripe_t           mem_q [MAX_STRIPES];
	logic [CW-1:0]     idx_q;
	logic              issue;
	logic              rd_valid_s1;
	logic [AW-1:0]     rd_idx_s1;
	stripe_t           rd_word_s1;
	logic              match;
	logic              hit;
	logic              found_q;
	logic [AW-1:0]     sel_idx_q;
	stripe_t           sel_word_q;

	// placement
	logic              vfail;
	logic              full;
	logic [W_DIM-1:0]  base_room;
	logic [W_DIM-1:0]  left_room;
	logic [W_DIM-1:0]  new_room;
	logic [W_DIM-1:0]  new_top;
	logic [W_DIM-1:0]  place_top;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	stripe_t           wr_word;
	logic              open_new;
	logic [W_STAT-1:0] status_d;

	assign v_in = {1'b0, req_height} + {{(W_DIV-W_MIN){1'b0}}, g_q} - 1'b1;

	spk_rem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (v_in),
		.divisor  (g_q),
		.rem      (rem),
		.done     (div_done)
	);

	// rounded height: value plus granule minus one, less the remainder; the plain height when the granule is zero
	assign rh_d = (g_q == '0) ? {1'b0, h_q} : v_q - {{(W_DIV-W_MIN){1'b0}}, rem};

	// request capture and rounded height
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q        <= req_width;
			h_q        <= req_height;
			v_q        <= v_in;
			oversize_q <= (req_width > aw_q) || (req_height > ah_q);
		end
		rh_q <= rh_d;
	end

	// scan over open stripes, one read issued a cycle
	assign issue = cmd.scan && !hit && (idx_q < count_q);
	assign match = (rd_word_s1.room >= w_q) && ({1'b0, rd_word_s1.height} == rh_q);
	assign hit   = rd_valid_s1 && match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else if (cmd.load) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.scan && hit) begin
				found_q <= 1'b1;
			end
		end
	end

	// table read port and hit capture
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_word_s1 <= mem_q[idx_q[AW-1:0]];
			rd_idx_s1  <= idx_q[AW-1:0];
		end
		if (cmd.scan && hit) begin
			sel_idx_q  <= rd_idx_s1;
			sel_word_q <= rd_word_s1;
		end
	end

	// placement decision
	assign vfail     = (rh_q > {1'b0, vroom_q}) || (vroom_q < {{(W_DIM-W_MIN){1'b0}}, g_q});
	assign full      = (count_q == CW'(MAX_STRIPES));
	assign base_room = found_q ? sel_word_q.room : aw_q;
	assign left_room = base_room - w_q;
	assign new_room  = (left_room < {{(W_DIM-W_MIN){1'b0}}, g_q}) ? '0 : left_room;
	assign new_top   = ah_q - vroom_q;
	assign place_top = found_q ? sel_word_q.top : new_top;

	always_comb begin
		open_new = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = sel_idx_q;
		wr_word  = sel_word_q;
		wr_word.room = new_room;
		if (oversize_q) begin
			status_d = ST_TOO_LARGE;
		end else if (found_q) begin
			status_d = ST_PLACED;
			wr_en    = cmd.place;
		end else if (vfail) begin
			status_d = ST_NO_ROOM;
		end else if (full) begin
			status_d = ST_TABLE_FULL;
		end else begin
			status_d       = ST_PLACED;
			open_new       = cmd.place;
			wr_en          = cmd.place;
			wr_addr        = count_q[AW-1:0];
			wr_word.height = rh_q[W_DIM-1:0];
			wr_word.top    = new_top;
		end
	end

	// table write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_word;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			status <= status_d;
			if (status_d == ST_PLACED) begin
				pos_x <= {1'b0, ox_q} + (aw_q - base_room);
				pos_y <= {1'b0, oy_q} + place_top;
			end else begin
				pos_x <= '0;
				pos_y <= '0;
			end
		end
	end

	// configuration registers; geometry writes empty the stripe table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q    <= W_DIM'(2048);
			ah_q    <= W_DIM'(2048);
			g_q     <= W_MIN'(32);
			ox_q    <= '0;
			oy_q    <= '0;
			count_q <= '0;
			vroom_q <= W_DIM'(2048);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ATLAS_W: begin
					aw_q    <= cfg_wdata[W_DIM-1:0];
					count_q <= '0;
					vroom_q <= ah_q;
				end
				CFG_ATLAS_H: begin
					ah_q    <= cfg_wdata[W_DIM-1:0];
					count_q <= '0;
					vroom_q <= cfg_wdata[W_DIM-1:0];
				end
				CFG_MIN_SIZE: begin
					g_q     <= cfg_wdata[W_MIN-1:0];
					count_q <= '0;
					vroom_q <= ah_q;
				end
				CFG_ORIGIN_X: begin
					ox_q <= cfg_wdata[W_ORG-1:0];
				end
				CFG_ORIGIN_Y: begin
					oy_q <= cfg_wdata[W_ORG-1:0];
				end
				default: begin
				end
			endcase
		end else if (open_new) begin
			count_q <= count_q + 1'b1;
			vroom_q <= vroom_q - rh_q[W_DIM-1:0];
		end
	end

	assign stat.oversize = oversize_q;
	assign stat.div_done = div_done;
	assign stat.scan_end = hit || (idx_q == count_q);

endmodule

/* sv/spk_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spk_checker
	import spk_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [W_STAT-1:0] status,
	input logic [W_DIM-1:0]  pos_x,
	input logic [W_DIM-1:0]  pos_y
);

	// a result is only shown once the block has gone idle
	`ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)

	// an accepted transfer makes the block busy next cycle
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// no two results in adjacent cycles
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

	// failed requests report a zero position
	`ASSERT_IMP(a_fail_zero, clk, arst_n, done && (status != ST_PLACED),
		(pos_x == '0) && (pos_y == '0))

endmodule

bind shelf_rectangle_packer spk_checker u_spk_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status),
	.pos_x  (pos_x),
	.pos_y  (pos_y)
);

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import spk_pkg::*;

	localparam int SHELVES = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 100;
	localparam logic [W_CFGI-1:0] CFG_SPARE_LO = 3'd5;
	localparam logic [W_CFGI-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum {SHAPE_MIXED, SHAPE_FILL, SHAPE_TIGHT, SHAPE_ORIGIN} phase_shape_t;

	typedef struct packed {
		logic [W_STAT-1:0] status;
		logic [W_DIM-1:0]  x;
		logic [W_DIM-1:0]  y;
	} placement_t;

	typedef struct {
		logic [W_DIM-1:0] w;
		logic [W_DIM-1:0] h;
		int               gap;
	} rect_req_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [W_DIM-1:0]  req_width = '0;
	logic [W_DIM-1:0]  req_height = '0;
	logic              done;
	logic [W_STAT-1:0] status;
	logic [W_DIM-1:0]  pos_x;
	logic [W_DIM-1:0]  pos_y;
	logic              cfg_we = 1'b0;
	logic [W_CFGI-1:0] cfg_index = '0;
	logic [W_CFGD-1:0] cfg_wdata = '0;

	shelf_rectangle_packer #(
		.MAX_STRIPES(SHELVES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_width(req_width),
		.req_height(req_height),
		.done(done),
		.status(status),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the allocator: geometry, origin and the shelf table
	int unsigned atlas_w, atlas_h, granule, org_x, org_y;
	int unsigned shelf_height [SHELVES];
	int unsigned shelf_top [SHELVES];
	int unsigned shelf_room [SHELVES];
	int unsigned shelf_count, free_height;

	rect_req_t  pending_reqs[$];
	placement_t expected_places[$];

	int sent_count, result_count, fault_count;
	int placed_count, too_large_count, no_room_count, full_count;
	int hold_cycles, stall_cycles;

	function automatic void empty_shelves();
		shelf_count = 0;
		free_height = atlas_h;
	endfunction

	function automatic void apply_reg(input logic [W_CFGI-1:0] idx,
			input logic [W_CFGD-1:0] val);
		case (idx)
			CFG_ATLAS_W: begin
				atlas_w = val;
				empty_shelves();
			end
			CFG_ATLAS_H: begin
				atlas_h = val;
				empty_shelves();
			end
			CFG_MIN_SIZE: begin
				granule = val[W_MIN-1:0];
				empty_shelves();
			end
			CFG_ORIGIN_X: org_x = val[W_ORG-1:0];
			CFG_ORIGIN_Y: org_y = val[W_ORG-1:0];
			default: ;
		endcase
	endfunction

	// works out where a rectangle lands and updates the shelf table
	function automatic placement_t place_rect(input int unsigned w, input int unsigned h);
		placement_t  res;
		int unsigned rh, xoff;
		int          sel, i;
		res = '0;
		if (w > atlas_w || h > atlas_h) begin
			res.status = ST_TOO_LARGE;
			return res;
		end
		rh = (granule == 0) ? h : ((h + granule - 1) / granule) * granule;
		sel = -1;
		for (i = 0; i < shelf_count; i++)
			if (sel < 0 && shelf_room[i] >= w && shelf_height[i] == rh)
				sel = i;
		if (sel < 0) begin
			if (rh > free_height || free_height < granule) begin
				res.status = ST_NO_ROOM;
				return res;
			end
			if (shelf_count >= SHELVES) begin
				res.status = ST_TABLE_FULL;
				return res;
			end
			sel = shelf_count;
			shelf_height[sel] = rh & 32'h7fff;
			shelf_top[sel] = (atlas_h - free_height) & 32'h7fff;
			shelf_room[sel] = atlas_w;
			shelf_count++;
			free_height -= rh;
		end
		xoff = atlas_w - shelf_room[sel];
		res.status = ST_PLACED;
		res.x = W_DIM'(org_x + xoff);
		res.y = W_DIM'(org_y + shelf_top[sel]);
		shelf_room[sel] -= w;
		if (shelf_room[sel] < granule)
			shelf_room[sel] = 0;
		return res;
	endfunction

	// request driver: each pending request waits its own gap before start rises
	always @(posedge clk or negedge arst_n) begin : drive
		rect_req_t nxt;
		placement_t want;
		if (!arst_n) begin
			start <= 1'b0;
			req_width <= '0;
			req_height <= '0;
			hold_cycles <= 0;
		end else if (start && !busy) begin
			want = place_rect(req_width, req_height);
			expected_places.push_back(want);
			sent_count++;
			case (want.status)
				ST_PLACED:    placed_count++;
				ST_TOO_LARGE: too_large_count++;
				ST_NO_ROOM:   no_room_count++;
				default:      full_count++;
			endcase
			hold_cycles <= 0;
			if (pending_reqs.size() != 0 && pending_reqs[0].gap == 0) begin
				nxt = pending_reqs.pop_front();
				req_width <= nxt.w;
				req_height <= nxt.h;
			end else begin
				start <= 1'b0;
			end
		end else if (!start && pending_reqs.size() != 0) begin
			if (hold_cycles + 1 >= pending_reqs[0].gap) begin
				nxt = pending_reqs.pop_front();
				req_width <= nxt.w;
				req_height <= nxt.h;
				start <= 1'b1;
			end else begin
				hold_cycles <= hold_cycles + 1;
			end
		end else if (!start) begin
			hold_cycles <= hold_cycles + 1;
		end
	end

	// result monitor: every done transfer is checked against the oldest prediction
	always @(posedge clk) begin : watch
		placement_t want;
		if (arst_n && done) begin
			result_count++;
			if (expected_places.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: status %0d x %0d y %0d",
						status, pos_x, pos_y);
			end else begin
				want = expected_places.pop_front();
				if (status !== want.status || pos_x !== want.x || pos_y !== want.y) begin
					fault_count++;
					if (fault_count <= 10)
						$display("result %0d: expected status %0d x %0d y %0d, got status %0d x %0d y %0d",
							result_count, want.status, want.x, want.y, status, pos_x, pos_y);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", stall_cycles);
				$display("tb_top failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [W_CFGI-1:0] idx, input logic [W_CFGD-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		apply_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_req(input int unsigned w, input int unsigned h, input bit burst);
		rect_req_t r;
		r.w = W_DIM'(w);
		r.h = W_DIM'(h);
		r.gap = burst ? 0 : $urandom_range(0, 6);
		pending_reqs.push_back(r);
	endtask

	// wait for the queue to empty and every result to come back
	task automatic drain();
		@(negedge clk);
		while (pending_reqs.size() != 0 || start || expected_places.size() != 0)
			@(negedge clk);
	endtask

	function automatic int unsigned pick_origin();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 16383;
			default: return $urandom_range(0, 16383);
		endcase
	endfunction

	function automatic int unsigned pick_extent();
		case ($urandom_range(0, 3))
			0: return 16384;
			1: return $urandom_range(1, 64);
			default: return $urandom_range(65, 4096);
		endcase
	endfunction

	function automatic int unsigned pick_granule();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 1;
			2: return 1024;
			default: return $urandom_range(2, 64);
		endcase
	endfunction

	// sequence of phases
	initial begin : stimulus
		phase_shape_t shapes[10];
		int           sizes[10];
		int unsigned  aw, ah, gr, pal[4], w, h, jit;
		int           p, n, r, hh;
		bit           burst;

		shapes = '{SHAPE_MIXED, SHAPE_FILL, SHAPE_TIGHT, SHAPE_ORIGIN, SHAPE_MIXED,
			SHAPE_FILL, SHAPE_MIXED, SHAPE_TIGHT, SHAPE_ORIGIN, SHAPE_MIXED};
		sizes = '{40, 70, 40, 40, 40, 70, 40, 40, 40, 40};

		atlas_w = 2048;
		atlas_h = 2048;
		granule = 32;
		org_x = 0;
		org_y = 0;
		empty_shelves();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry: oversize, zero sizes, shelf reuse, leftover cleared
		push_req(2049, 10, 0);
		push_req(10, 2049, 0);
		push_req(0, 0, 0);
		push_req(0, 40, 0);
		push_req(2000, 33, 0);
		push_req(20, 64, 0);
		push_req(1, 50, 0);
		push_req(2048, 2048, 0);
		push_req(16384, 16384, 0);
		push_req(32767, 32767, 0);
		drain();

		// largest atlas, no rounding, origin at its largest value
		write_reg(CFG_ATLAS_W, 16384);
		write_reg(CFG_ATLAS_H, 16384);
		write_reg(CFG_MIN_SIZE, 0);
		write_reg(CFG_ORIGIN_X, 16383);
		write_reg(CFG_ORIGIN_Y, 16383);
		@(negedge clk);
		push_req(16384, 16384, 1);
		push_req(0, 0, 1);
		push_req(1, 1, 1);
		push_req(16385, 1, 0);
		drain();

		// smallest atlas with the largest granule: never any vertical room
		write_reg(CFG_ATLAS_W, 1);
		write_reg(CFG_ATLAS_H, 1);
		write_reg(CFG_MIN_SIZE, 1024);
		write_reg(CFG_ORIGIN_X, 0);
		write_reg(CFG_ORIGIN_Y, 0);
		@(negedge clk);
		push_req(1, 1, 0);
		push_req(0, 0, 0);
		push_req(2, 1, 0);
		push_req(1, 2, 0);
		drain();

		// rounding past the atlas, spare indexes and origin writes keep the shelves
		write_reg(CFG_ATLAS_W, 16384);
		write_reg(CFG_ATLAS_H, 16384);
		write_reg(CFG_MIN_SIZE, 1000);
		@(negedge clk);
		push_req(16, 16001, 0);
		push_req(16, 15361, 0);
		push_req(16, 16384, 0);
		drain();
		write_reg(CFG_SPARE_LO, W_CFGD'($urandom));
		write_reg(CFG_SPARE_HI, W_CFGD'($urandom));
		@(negedge clk);
		push_req(16, 15999, 0);
		drain();
		write_reg(CFG_ORIGIN_X, 100);
		@(negedge clk);
		push_req(16, 15999, 0);
		push_req(0, 0, 0);
		drain();

		// random phases
		for (p = 0; p < 10; p++) begin
			burst = ($urandom_range(0, 3) == 0);
			case (shapes[p])
				SHAPE_MIXED: begin
					aw = pick_extent();
					ah = pick_extent();
					gr = pick_granule();
				end
				SHAPE_FILL: begin
					aw = $urandom_range(1, 64);
					ah = 16384;
					gr = $urandom_range(0, 2);
				end
				SHAPE_TIGHT: begin
					aw = $urandom_range(32, 256);
					ah = $urandom_range(64, 512);
					gr = $urandom_range(8, 64);
				end
				default: begin
					aw = atlas_w;
					ah = atlas_h;
					gr = granule;
				end
			endcase
			if (shapes[p] != SHAPE_ORIGIN) begin
				write_reg(CFG_ATLAS_W, W_CFGD'(aw));
				write_reg(CFG_ATLAS_H, W_CFGD'(ah));
				// spare upper bits ride along and must be dropped
				write_reg(CFG_MIN_SIZE, {4'($urandom), W_MIN'(gr)});
			end
			write_reg(CFG_ORIGIN_X, {1'($urandom), W_ORG'(pick_origin())});
			write_reg(CFG_ORIGIN_Y, {1'($urandom), W_ORG'(pick_origin())});
			@(negedge clk);
			for (n = 0; n < 4; n++)
				pal[n] = $urandom_range(0, ah / 4 + 1);
			for (n = 0; n < sizes[p]; n++) begin
				r = $urandom_range(0, 99);
				if (shapes[p] == SHAPE_FILL && r < 85) begin
					w = (r < 70) ? aw : $urandom_range(0, aw);
					h = $urandom_range(0, 40);
				end else if (shapes[p] == SHAPE_TIGHT && r < 85) begin
					w = $urandom_range(0, aw);
					h = $urandom_range(0, ah / 3);
				end else if (r < 75) begin
					// well-formed: a height near one of a few shelf heights
					w = (r < 60) ? $urandom_range(0, aw / 4 + 1) : $urandom_range(0, aw);
					jit = (gr > 0) ? $urandom_range(0, gr - 1) : 0;
					hh = int'(pal[$urandom_range(0, 3)]) - int'(jit);
					h = (hh < 0) ? 0 : hh;
				end else if (r < 85) begin
					w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, aw);
					h = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, ah);
				end else if (r < 95) begin
					w = (r < 90) ? $urandom_range(aw + 1, 32767) : $urandom_range(0, aw);
					h = (r < 90) ? $urandom_range(0, ah) : $urandom_range(ah + 1, 32767);
				end else begin
					w = $urandom_range(0, 32767);
					h = $urandom_range(0, 32767);
				end
				push_req(w, h, burst);
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		fault_count += expected_places.size();
		$display("%0d requests over directed and random geometries, %0d results checked",
			sent_count, result_count);
		$display("placed %0d, too large %0d, no vertical room %0d, shelf table full %0d",
			placed_count, too_large_count, no_room_count, full_count);
		if (fault_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("%0d faults", fault_count);
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
